// ===== hw/rtl/csp_pkg.sv =====
package csp_pkg;

    // table geometry
    localparam int MAX_ALTS   = 16;
    localparam int RESULT_CAP = 16;
    localparam int IDX_W      = $clog2(MAX_ALTS);
    localparam int CNT_W      = $clog2(MAX_ALTS + 1);
    localparam int EMIT_CAP   = (MAX_ALTS < RESULT_CAP) ? MAX_ALTS : RESULT_CAP;

    // field widths
    localparam int CMD_W   = 2;
    localparam int LET_W   = 8;
    localparam int SCORE_W = 8;
    localparam int DELTA_W = 11;
    localparam int SLOT_W  = 4;
    localparam int VAL_W   = DELTA_W + 1;

    // score rule constants
    localparam int ABS_MARK    = 512;
    localparam int SCORE_CAP   = 254;
    localparam int FIRST_STEP  = 8;
    localparam int SCORE_FLOOR = 2;

    localparam logic signed [VAL_W-1:0] V_ABS_MARK   = VAL_W'(ABS_MARK);
    localparam logic signed [VAL_W-1:0] V_SCORE_CAP  = VAL_W'(SCORE_CAP);
    localparam logic signed [VAL_W-1:0] V_FIRST_STEP = VAL_W'(FIRST_STEP);
    localparam logic signed [VAL_W-1:0] V_FLOOR      = VAL_W'(SCORE_FLOOR);

    // input commands
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROMOTE = 2'd2;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_IDLE     = 4'd0;
    localparam t_op OP_SRCH     = 4'd1;
    localparam t_op OP_UPD      = 4'd2;
    localparam t_op OP_INS      = 4'd3;
    localparam t_op OP_SORT_LD  = 4'd4;
    localparam t_op OP_SORT_CUR = 4'd5;
    localparam t_op OP_CMP      = 4'd6;
    localparam t_op OP_PUT      = 4'd7;
    localparam t_op OP_EMIT_LD  = 4'd8;
    localparam t_op OP_EMIT     = 4'd9;
    localparam t_op OP_EMPTY    = 4'd10;

    typedef struct packed {
        logic [LET_W-1:0]   letter;
        logic [LET_W-1:0]   cls;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic srch_hit;
        logic scan_last;
        logic pos_last;
        logic delta_neg;
        logic cur_zero;
        logic emit_last;
    } t_stat;

endpackage

// ===== hw/rtl/candidate_score_promoter_top.sv =====
// clear and append are taken while idle and never raise busy; command 3 is dropped
// promote: search, then update on a hit or insert on a miss, sort load, sort, emit load,
// emit of up to 16 entries; a miss with a negative delta skips the insert and the sort
// for a full table the sort loop dominates; an empty table goes straight to the empty beat
// one beat per cycle, the last one in the first cycle busy is low; receiver cannot stall
// i_rst_n is synchronous: clears the controller, entry count and strobe, table undefined
module candidate_score_promoter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [csp_pkg::CMD_W-1:0]          i_command,
    input  logic [csp_pkg::LET_W-1:0]          i_letter,
    input  logic [csp_pkg::LET_W-1:0]          i_letter_class,
    input  logic [csp_pkg::SCORE_W-1:0]        i_score,
    input  logic signed [csp_pkg::DELTA_W-1:0] i_delta,
    output logic                               o_strobe,
    output logic [csp_pkg::SLOT_W-1:0]         o_slot,
    output logic [csp_pkg::LET_W-1:0]          o_out_letter,
    output logic [csp_pkg::SCORE_W-1:0]        o_out_score,
    output logic                               o_table_empty,
    output logic                               o_last_entry
);
    import csp_pkg::*;

    // command and status between the sequencer and the table datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: search, update or insert, selection sort, emit
    csp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy)
    );

    // table memory, score arithmetic and result register
    csp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_command),
        .i_letter       (i_letter),
        .i_letter_class (i_letter_class),
        .i_score        (i_score),
        .i_delta        (i_delta),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_slot         (o_slot),
        .o_out_letter   (o_out_letter),
        .o_out_score    (o_out_score),
        .o_table_empty  (o_table_empty),
        .o_last_entry   (o_last_entry)
    );

endmodule

// ===== hw/rtl/csp_ctrl.sv =====
module csp_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [csp_pkg::CMD_W-1:0] i_command,
    input  csp_pkg::t_stat            i_stat,
    output csp_pkg::t_cmd             o_cmd,
    output logic                      o_busy
);
    import csp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH     = 4'd1;
    localparam logic [3:0] S_UPD      = 4'd2;
    localparam logic [3:0] S_INS      = 4'd3;
    localparam logic [3:0] S_SORT_LD  = 4'd4;
    localparam logic [3:0] S_SORT_CUR = 4'd5;
    localparam logic [3:0] S_CMP      = 4'd6;
    localparam logic [3:0] S_PUT      = 4'd7;
    localparam logic [3:0] S_EMIT_LD  = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;
    localparam logic [3:0] S_EMPTY    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign accept = (r_state == S_IDLE) && i_start;
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd.op = OP_IDLE;
        o_cmd.accept = accept;
        case (r_state)
            S_IDLE: begin
                o_cmd.op = OP_IDLE;
                if (accept && (i_command == CMD_PROMOTE)) begin
                    n_state = i_stat.cnt_zero ? S_EMPTY : S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.op = OP_SRCH;
                if (i_stat.srch_hit) begin
                    n_state = S_UPD;
                end else if (i_stat.scan_last) begin
                    n_state = i_stat.delta_neg ? S_EMIT_LD : S_INS;
                end
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_state = S_SORT_LD;
            end
            S_INS: begin
                o_cmd.op = OP_INS;
                n_state = S_SORT_LD;
            end
            S_SORT_LD: begin
                o_cmd.op = OP_SORT_LD;
                n_state = S_SORT_CUR;
            end
            S_SORT_CUR: begin
                o_cmd.op = OP_SORT_CUR;
                n_state = i_stat.pos_last ? S_PUT : S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                if (i_stat.scan_last) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.op = OP_PUT;
                if (i_stat.cur_zero || i_stat.pos_last) begin
                    n_state = S_EMIT_LD;
                end else begin
                    n_state = S_SORT_CUR;
                end
            end
            S_EMIT_LD: begin
                o_cmd.op = OP_EMIT_LD;
                n_state = i_stat.cnt_zero ? S_EMPTY : S_EMIT;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                o_cmd.op = OP_EMPTY;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/csp_dpath.sv =====
module csp_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  csp_pkg::t_cmd                      i_cmd,
    input  logic [csp_pkg::CMD_W-1:0]          i_command,
    input  logic [csp_pkg::LET_W-1:0]          i_letter,
    input  logic [csp_pkg::LET_W-1:0]          i_letter_class,
    input  logic [csp_pkg::SCORE_W-1:0]        i_score,
    input  logic signed [csp_pkg::DELTA_W-1:0] i_delta,
    output csp_pkg::t_stat                     o_stat,
    output logic                               o_strobe,
    output logic [csp_pkg::SLOT_W-1:0]         o_slot,
    output logic [csp_pkg::LET_W-1:0]          o_out_letter,
    output logic [csp_pkg::SCORE_W-1:0]        o_out_score,
    output logic                               o_table_empty,
    output logic                               o_last_entry
);
    import csp_pkg::*;

    // entry table
    t_entry mem [MAX_ALTS];

    t_entry                     r_rd;
    t_entry                     r_hit;
    t_entry                     r_cur;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_j;
    logic [IDX_W-1:0]           r_i;
    logic [IDX_W-1:0]           r_hit_idx;
    logic [LET_W-1:0]           r_let;
    logic [LET_W-1:0]           r_cls;
    logic signed [DELTA_W-1:0]  r_delta;
    logic [SCORE_W-1:0]         r_score0;

    logic                       r_strobe;
    logic [SLOT_W-1:0]          r_slot;
    logic [LET_W-1:0]           r_oletter;
    logic [SCORE_W-1:0]         r_oscore;
    logic                       r_oempty;
    logic                       r_olast;

    logic                       we;
    logic [IDX_W-1:0]           waddr;
    t_entry                     wdata;
    logic [IDX_W-1:0]           raddr;

    logic [CNT_W-1:0]           j_next;
    logic [CNT_W-1:0]           i_next;
    logic [IDX_W-1:0]           i_inc;
    logic                       count_full;
    logic                       greater;

    logic                       is_upd;
    logic                       d_pos;
    logic                       d_abs;
    logic signed [VAL_W-1:0]    delta_x;
    logic signed [VAL_W-1:0]    floor_abs;
    logic signed [VAL_W-1:0]    base_own;
    logic signed [VAL_W-1:0]    score0_x;
    logic signed [VAL_W-1:0]    hit_x;
    logic signed [VAL_W-1:0]    step;
    logic signed [VAL_W-1:0]    raise_v;
    logic signed [VAL_W-1:0]    raise_c;
    logic signed [VAL_W-1:0]    lower_v;
    logic signed [VAL_W-1:0]    lower_c;
    logic [SCORE_W-1:0]         new_score;

    assign j_next     = r_j + 1'b1;
    assign i_next     = CNT_W'(r_i) + 1'b1;
    assign i_inc      = r_i + 1'b1;
    assign count_full = (r_count == CNT_W'(MAX_ALTS));
    assign greater    = (r_rd.score > r_cur.score);

    // score update
    assign is_upd    = (i_cmd.op == OP_UPD);
    assign delta_x   = VAL_W'(r_delta);
    assign d_pos     = (delta_x > 0);
    assign d_abs     = (delta_x > V_ABS_MARK);
    assign floor_abs = delta_x - V_ABS_MARK;
    assign score0_x  = VAL_W'(r_score0);
    assign hit_x     = VAL_W'(r_hit.score);
    assign base_own  = is_upd ? hit_x : score0_x;
    assign step      = (is_upd && (r_hit_idx == '0)) ? V_FIRST_STEP : delta_x;
    assign raise_v   = d_abs ? ((base_own < floor_abs) ? floor_abs : base_own)
                             : (score0_x + step);
    assign raise_c   = (raise_v > V_SCORE_CAP) ? V_SCORE_CAP : raise_v;
    assign lower_v   = hit_x + delta_x;
    assign lower_c   = (lower_v <= V_FLOOR) ? V_FLOOR : lower_v;
    assign new_score = (is_upd && !d_pos) ? lower_c[SCORE_W-1:0] : raise_c[SCORE_W-1:0];

    // table write and read address
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = r_cur;
        raddr = '0;
        case (i_cmd.op)
            OP_IDLE: begin
                if (i_cmd.accept && (i_command == CMD_APPEND) && !count_full) begin
                    we    = 1'b1;
                    waddr = r_count[IDX_W-1:0];
                    wdata = '{letter: i_letter, cls: i_letter_class, score: i_score};
                end
            end
            OP_SRCH: begin
                raddr = j_next[IDX_W-1:0];
            end
            OP_UPD: begin
                we    = 1'b1;
                waddr = r_hit_idx;
                wdata = '{letter: r_hit.letter, cls: r_hit.cls, score: new_score};
            end
            OP_INS: begin
                we    = 1'b1;
                waddr = count_full ? IDX_W'(MAX_ALTS - 1) : r_count[IDX_W-1:0];
                wdata = '{letter: r_let, cls: r_cls, score: new_score};
            end
            OP_SORT_LD: begin
                raddr = r_i;
            end
            OP_SORT_CUR: begin
                raddr = i_inc;
            end
            OP_CMP: begin
                we    = greater;
                waddr = r_j[IDX_W-1:0];
                raddr = j_next[IDX_W-1:0];
            end
            OP_PUT: begin
                we    = 1'b1;
                waddr = r_i;
                raddr = i_inc;
            end
            OP_EMIT: begin
                raddr = j_next[IDX_W-1:0];
            end
            default: begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_IDLE: begin
                if (i_cmd.accept) begin
                    r_let   <= i_letter;
                    r_cls   <= i_letter_class;
                    r_delta <= i_delta;
                    r_j     <= '0;
                end
            end
            OP_SRCH: begin
                if (r_j == '0) begin
                    r_score0 <= r_rd.score;
                end
                r_hit     <= r_rd;
                r_hit_idx <= r_j[IDX_W-1:0];
                r_j       <= j_next;
            end
            OP_UPD, OP_INS: begin
                r_i <= '0;
            end
            OP_SORT_CUR: begin
                r_cur <= r_rd;
                r_j   <= i_next;
            end
            OP_CMP: begin
                if (greater) begin
                    r_cur <= r_rd;
                end
                r_j <= j_next;
            end
            OP_PUT: begin
                r_i <= i_inc;
            end
            OP_EMIT_LD: begin
                r_j <= '0;
            end
            OP_EMIT: begin
                r_j <= j_next;
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.op)
                OP_IDLE: begin
                    if (i_cmd.accept && (i_command == CMD_CLEAR)) begin
                        r_count <= '0;
                    end else if (i_cmd.accept && (i_command == CMD_APPEND) && !count_full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_INS: begin
                    if (!count_full) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_PUT: begin
                    // zero scores sink to the end: drop them all
                    if (r_cur.score == '0) begin
                        r_count <= CNT_W'(r_i);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == OP_EMIT) || (i_cmd.op == OP_EMPTY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMPTY) begin
            r_slot    <= '0;
            r_oletter <= '0;
            r_oscore  <= '0;
            r_oempty  <= 1'b1;
            r_olast   <= 1'b1;
        end else begin
            r_slot    <= SLOT_W'(r_j);
            r_oletter <= r_rd.letter;
            r_oscore  <= r_rd.score;
            r_oempty  <= 1'b0;
            r_olast   <= o_stat.emit_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_slot        = r_slot;
    assign o_out_letter  = r_oletter;
    assign o_out_score   = r_oscore;
    assign o_table_empty = r_oempty;
    assign o_last_entry  = r_olast;

    assign o_stat.cnt_zero  = (r_count == '0);
    assign o_stat.srch_hit  = (r_rd.cls == r_cls);
    assign o_stat.scan_last = (j_next == r_count);
    assign o_stat.pos_last  = (i_next == r_count);
    assign o_stat.delta_neg = r_delta[DELTA_W-1];
    assign o_stat.cur_zero  = (r_cur.score == '0);
    assign o_stat.emit_last = (j_next == r_count) || (j_next == CNT_W'(EMIT_CAP));

endmodule
